// ===== rtl/core/sorted_list_priority_queue_top_assert.svh =====
// ----------------------------------------------------------------------------
// Sorted list priority queue assertion macros
// Shorthand for clocked implications used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_LIST_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, idle during reset.
`define SLPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, idle during reset.
`define SLPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/slpq_pkg.sv =====
// ----------------------------------------------------------------------------
// slpq_pkg
// Shared types and codes for the sorted list priority queue.
// ----------------------------------------------------------------------------
package slpq_pkg;

  localparam int KEY_W   = 32;
  localparam int COUNT_W = 5;

  // Request action codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE
  } cell_op_t;

  // Broadcast to every cell of the row
  typedef struct packed {
    cell_op_t                 op;
    logic signed [KEY_W-1:0]  key;
  } cell_cmd_t;

endpackage

// ===== rtl/core/slpq_cell.sv =====
// ----------------------------------------------------------------------------
// slpq_cell
// One slot of the sorted row: compare against the broadcast key and shift.
// ----------------------------------------------------------------------------
module slpq_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  slpq_pkg::cell_cmd_t                 cmd,
  input  logic                                left_keep,
  input  logic signed [slpq_pkg::KEY_W-1:0]   left_value,
  input  logic                                left_valid,
  input  logic signed [slpq_pkg::KEY_W-1:0]   right_value,
  input  logic                                right_valid,
  output logic                                keep,
  output logic signed [slpq_pkg::KEY_W-1:0]   value_q,
  output logic                                valid_q
);

  // Hold when the stored key is not greater than the new one (ties stay ahead)
  assign keep = valid_q && !(cmd.key < value_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else begin
      case (cmd.op)
        slpq_pkg::OP_INSERT: begin
          if (!keep) begin
            if (left_keep) begin
              valid_q <= 1'b1;
            end else begin
              valid_q <= left_valid;
            end
          end
        end
        slpq_pkg::OP_REMOVE: valid_q <= right_valid;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      slpq_pkg::OP_INSERT: begin
        if (!keep) begin
          value_q <= left_keep ? cmd.key : left_value;
        end
      end
      slpq_pkg::OP_REMOVE: value_q <= right_value;
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/sorted_list_priority_queue_top.sv =====
// Latency: a result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle while out_ready is high; the row of
//   compare-and-shift cells moves all cells together on insert or remove.
// A new request is taken in the same cycle the pending result is taken.
// Reset: clears the fill count, the cell valid bits and the output valid;
//   stored keys are not cleared.
// ----------------------------------------------------------------------------
// sorted_list_priority_queue_top
// Min priority queue built from a row of sorted cells, ties leave in order.
// ----------------------------------------------------------------------------
module sorted_list_priority_queue_top #(
  parameter int CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          action,
  input  logic signed [slpq_pkg::KEY_W-1:0]   value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [slpq_pkg::KEY_W-1:0]   removed_value,
  output logic signed [slpq_pkg::KEY_W-1:0]   min_value,
  output logic [slpq_pkg::COUNT_W-1:0]        count,
  output logic                                empty_res,
  output logic                                overflow,
  output logic                                underflow
);

  localparam int HELD_W = $clog2(CAPACITY + 1);

  logic                                accept;
  logic                                full;
  logic                                is_empty;
  logic [HELD_W-1:0]                   held;
  logic [HELD_W+slpq_pkg::COUNT_W-1:0] held_ext;
  slpq_pkg::cell_cmd_t                 cmd;

  // Per-cell state and the neighbor links of the row
  logic signed [slpq_pkg::KEY_W-1:0]   cell_value [CAPACITY];
  logic                                cell_valid [CAPACITY];
  logic                                cell_keep  [CAPACITY];

  // Take a new request when no result waits, or when it leaves this cycle
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign full     = (held == HELD_W'(CAPACITY));
  assign is_empty = (held == '0);

  // Drop an insert into a full row and a remove from an empty one
  always_comb begin
    cmd.key = value;
    cmd.op  = slpq_pkg::OP_HOLD;
    if (accept) begin
      if (action == slpq_pkg::ACT_INSERT && !full) begin
        cmd.op = slpq_pkg::OP_INSERT;
      end else if (action == slpq_pkg::ACT_REMOVE && !is_empty) begin
        cmd.op = slpq_pkg::OP_REMOVE;
      end
    end
  end

  // Cell 0 sees an always-keeping left side, so it takes the key when it
  // does not keep its own; the last cell pulls an empty slot on remove.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                              l_keep;
    logic signed [slpq_pkg::KEY_W-1:0] l_value;
    logic                              l_valid;
    logic signed [slpq_pkg::KEY_W-1:0] r_value;
    logic                              r_valid;

    if (i == 0) begin : g_head
      assign l_keep  = 1'b1;
      assign l_value = '0;
      assign l_valid = 1'b0;
    end else begin : g_body
      assign l_keep  = cell_keep[i-1];
      assign l_value = cell_value[i-1];
      assign l_valid = cell_valid[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_value = '0;
      assign r_valid = 1'b0;
    end else begin : g_link
      assign r_value = cell_value[i+1];
      assign r_valid = cell_valid[i+1];
    end

    slpq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .left_keep   (l_keep),
      .left_value  (l_value),
      .left_valid  (l_valid),
      .right_value (r_value),
      .right_valid (r_valid),
      .keep        (cell_keep[i]),
      .value_q     (cell_value[i]),
      .valid_q     (cell_valid[i])
    );
  end

  // Control: fill count and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        slpq_pkg::OP_INSERT: held <= held + HELD_W'(1);
        slpq_pkg::OP_REMOVE: held <= held - HELD_W'(1);
        default: ;
      endcase
    end
  end

  // Result payload captured with the request
  always_ff @(posedge clk) begin
    if (accept) begin
      removed_value <= (cmd.op == slpq_pkg::OP_REMOVE) ? cell_value[0] : '0;
      overflow      <= (action == slpq_pkg::ACT_INSERT) && full;
      underflow     <= (action == slpq_pkg::ACT_REMOVE) && is_empty;
    end
  end

  // The row holds still while a result waits, so read the head directly
  assign min_value = cell_valid[0] ? cell_value[0] : '0;
  assign held_ext  = {{slpq_pkg::COUNT_W{1'b0}}, held};
  assign count     = held_ext[slpq_pkg::COUNT_W-1:0];
  assign empty_res = is_empty;

endmodule

// ===== rtl/core/sorted_list_priority_queue_checker.sv =====
// ----------------------------------------------------------------------------
// sorted_list_priority_queue_checker
// Port-level checks on the result channel of the priority queue.
// ----------------------------------------------------------------------------
`include "sorted_list_priority_queue_top_assert.svh"

module sorted_list_priority_queue_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [slpq_pkg::KEY_W-1:0]   removed_value,
  input logic signed [slpq_pkg::KEY_W-1:0]   min_value,
  input logic [slpq_pkg::COUNT_W-1:0]        count,
  input logic                                empty_res,
  input logic                                overflow,
  input logic                                underflow
);

  `SLPQ_ASSERT_NOW(a_empty_matches_count, out_valid, empty_res == (count == '0), "empty flag disagrees with count")
  `SLPQ_ASSERT_NOW(a_flags_exclusive, out_valid, !(overflow && underflow), "overflow and underflow together")
  `SLPQ_ASSERT_NOW(a_underflow_clean, out_valid && underflow, empty_res && removed_value == '0 && min_value == '0, "underflow result not empty")
  `SLPQ_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid, "result dropped before taken")

endmodule

bind sorted_list_priority_queue_top sorted_list_priority_queue_checker u_checker (.*);
